// ----- hdl/kcc_pkg.sv -----
// Package for the key click classifier: sizes, mode and event codes,
// register indices and the layout of one per-key state entry.
// Depends on nothing; every other file of the block imports it.
package kcc_pkg;

	localparam int NUM_KEYS   = 8;
	localparam int TIMER_BITS = 16;
	localparam int KEY_W      = 3;
	localparam int IDX_W      = $clog2(NUM_KEYS);
	localparam int CNT_W      = 4;
	localparam int THR_W      = 16;
	localparam int CMP_W      = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [4:0] {
		MODE_IDLE     = 5'b00001,
		MODE_DEBOUNCE = 5'b00010,
		MODE_PRESSED  = 5'b00100,
		MODE_LONG     = 5'b01000,
		MODE_RELEASED = 5'b10000
	} mode_t;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESS   = 3'd1,
		EV_LONG    = 3'd2,
		EV_RELEASE = 3'd3,
		EV_CLICK   = 3'd4,
		EV_DOUBLE  = 3'd5
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_COUNT    = 3'd0,
		CFG_POLARITY     = 3'd1,
		CFG_DEBOUNCE     = 3'd2,
		CFG_LONG_PRESS   = 3'd3,
		CFG_DOUBLE_CLICK = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		mode_t                 mode;
		logic [TIMER_BITS-1:0] timer;
		logic                  prev;
	} key_entry_t;

	localparam key_entry_t STATE_RESET = '{mode: MODE_IDLE, timer: '0, prev: 1'b0};

endpackage

// ----- hdl/kcc_tick_if.sv -----
// Channel carrying one tick sample of one key.
// Depends on kcc_pkg.
interface kcc_tick_if;
	import kcc_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_index;
	logic             pin_level;

	modport source (output valid, key_index, pin_level, input ready);
	modport sink (input valid, key_index, pin_level, output ready);
endinterface

// ----- hdl/kcc_result_if.sv -----
// Channel carrying one classified key event.
// Depends on kcc_pkg.
interface kcc_result_if;
	import kcc_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] event_key;
	logic [2:0]       event_code;
	logic             is_held;

	modport source (output valid, event_key, event_code, is_held, input ready);
	modport sink (input valid, event_key, event_code, is_held, output ready);
endinterface

// ----- hdl/kcc_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on kcc_pkg.
interface kcc_cfg_if;
	import kcc_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/key_click_classifier_top.sv -----
// Key click classifier: debounces per-key tick samples and reports press, long press,
// release, click and double click events, one result transaction per sample.
// Depends on kcc_pkg, kcc_tick_if, kcc_result_if and kcc_cfg_if.
//
// A new sample is accepted every clock cycle unless the output stalls.
// The per-key state sits in one memory of NUM_KEYS entries with a registered read port:
// the sample's entry is read on acceptance, updated in the following cycle and written
// back as the result enters the output register; a write to the key read in the same
// cycle is forwarded. Per-entry valid bits make the state clear immediately after reset.
// Configuration writes are always accepted and take effect on the next cycle.
module key_click_classifier_top (
	input logic clk,
	input logic arst_n,
	kcc_tick_if.sink tick,
	kcc_result_if.source result,
	kcc_cfg_if.sink cfg
);
	import kcc_pkg::*;

	logic [CNT_W-1:0]    key_count_q;
	logic [NUM_KEYS-1:0] polarity_q;
	logic [THR_W-1:0]    debounce_q;
	logic [THR_W-1:0]    long_press_q;
	logic [THR_W-1:0]    double_click_q;

	key_entry_t          mem_q [NUM_KEYS];
	logic [NUM_KEYS-1:0] valid_q;

	logic             s1_valid_q;
	logic [KEY_W-1:0] key_s1;
	logic             raw_s1;
	key_entry_t       rd_s1;
	logic             rd_valid_s1;
	logic             fwd_s1;
	key_entry_t       fwd_data_s1;

	logic             out_valid_q;
	logic [KEY_W-1:0] out_key_q;
	event_t           out_code_q;
	logic             out_held_q;

	logic             tick_acc;
	logic             adv;
	logic             active;
	logic             wr_en;
	logic             cur;
	logic             rise;
	key_entry_t       st;
	key_entry_t       nxt;
	event_t           ev;
	logic [TIMER_BITS-1:0] t_inc;
	logic [CMP_W-1:0] t_inc_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q    <= '0;
			polarity_q     <= '1;
			debounce_q     <= THR_W'(20);
			long_press_q   <= THR_W'(1000);
			double_click_q <= THR_W'(300);
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				CFG_KEY_COUNT:    key_count_q    <= cfg.data[CNT_W-1:0];
				CFG_POLARITY:     polarity_q     <= cfg.data[NUM_KEYS-1:0];
				CFG_DEBOUNCE:     debounce_q     <= cfg.data[THR_W-1:0];
				CFG_LONG_PRESS:   long_press_q   <= cfg.data[THR_W-1:0];
				CFG_DOUBLE_CLICK: double_click_q <= cfg.data[THR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv        = s1_valid_q && (!out_valid_q || result.ready);
	assign tick.ready = !s1_valid_q || adv;
	assign tick_acc   = tick.valid && tick.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (tick_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			key_s1      <= tick.key_index;
			raw_s1      <= tick.pin_level;
			rd_s1       <= mem_q[tick.key_index[IDX_W-1:0]];
			rd_valid_s1 <= valid_q[tick.key_index[IDX_W-1:0]];
			fwd_s1      <= wr_en && (key_s1 == tick.key_index);
			fwd_data_s1 <= nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[key_s1[IDX_W-1:0]] <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[key_s1[IDX_W-1:0]] <= 1'b1;
		end
	end

	assign active = ({1'b0, key_s1} < key_count_q) && ({1'b0, key_s1} < CNT_W'(NUM_KEYS));
	assign wr_en  = adv && active;

	always_comb begin
		st        = fwd_s1 ? fwd_data_s1 : (rd_valid_s1 ? rd_s1 : STATE_RESET);
		cur       = polarity_q[key_s1[IDX_W-1:0]] ? !raw_s1 : raw_s1;
		rise      = cur && !st.prev;
		t_inc     = (st.timer == '1) ? st.timer : st.timer + TIMER_BITS'(1);
		t_inc_ext = CMP_W'(t_inc);
		nxt       = st;
		nxt.prev  = cur;
		ev        = EV_NONE;
		case (st.mode)
			MODE_IDLE: begin
				if (rise) begin
					nxt.mode  = MODE_DEBOUNCE;
					nxt.timer = '0;
				end
			end
			MODE_DEBOUNCE: begin
				if (cur) begin
					nxt.timer = t_inc;
					if (t_inc_ext >= CMP_W'(debounce_q)) begin
						nxt.mode  = MODE_PRESSED;
						nxt.timer = '0;
						ev        = EV_PRESS;
					end
				end else begin
					nxt.mode = MODE_IDLE;
				end
			end
			MODE_PRESSED: begin
				if (cur) begin
					nxt.timer = t_inc;
					if (t_inc_ext >= CMP_W'(long_press_q)) begin
						nxt.mode = MODE_LONG;
						ev       = EV_LONG;
					end
				end else begin
					nxt.mode  = MODE_RELEASED;
					nxt.timer = '0;
					ev        = EV_RELEASE;
				end
			end
			MODE_LONG: begin
				if (!cur) begin
					nxt.mode = MODE_IDLE;
					ev       = EV_RELEASE;
				end
			end
			MODE_RELEASED: begin
				nxt.timer = t_inc;
				if (rise) begin
					nxt.mode = MODE_IDLE;
					ev       = EV_DOUBLE;
				end else if (t_inc_ext >= CMP_W'(double_click_q)) begin
					nxt.mode = MODE_IDLE;
					ev       = EV_CLICK;
				end
			end
			default: begin
				nxt.mode = MODE_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_key_q  <= key_s1;
			out_code_q <= active ? ev : EV_NONE;
			out_held_q <= active && cur;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.event_key  = out_key_q;
	assign result.event_code = out_code_q;
	assign result.is_held    = out_held_q;

	// An accepted sample always occupies the update stage in the next cycle.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> s1_valid_q)
		else $error("accepted sample did not reach the update stage");

	// Forwarded state is only ever used by a live sample.
	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 && !s1_valid_q |-> !tick_acc || !wr_en)
		else $error("forwarding flagged without a sample in flight");

	// An unregistered key yields an empty event with the key released.
	a_unreg_none: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !active |=> result.valid && result.event_code == EV_NONE && !result.is_held)
		else $error("unregistered key produced an event");

	// A write-back marks its entry as holding valid state.
	a_wr_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(key_s1[IDX_W-1:0])])
		else $error("written entry not marked valid");

	// A result moves into the output register only when the previous one has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv |-> !out_valid_q || result.ready)
		else $error("pending result overwritten");

endmodule

// ----- tb/tb_key_click_classifier_top.sv -----
// Testbench for the key click classifier: directed key sequences, threshold extremes,
// output back-pressure and random multi-key traffic, checked against a per-key predictor.
// Depends on kcc_pkg, kcc_tick_if, kcc_result_if, kcc_cfg_if and key_click_classifier_top.
module tb_key_click_classifier_top;
	import kcc_pkg::*;

	localparam int STALL_LIMIT = 2000;

	typedef struct {
		logic [KEY_W-1:0] key;
		event_t           code;
		logic             held;
	} predicted_t;

	logic clk;
	logic arst_n;

	kcc_tick_if   tick_ch();
	kcc_result_if result_ch();
	kcc_cfg_if    cfg_ch();

	key_click_classifier_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic [CNT_W-1:0]      reg_key_count;
	logic [7:0]            reg_polarity;
	logic [THR_W-1:0]      reg_debounce;
	logic [THR_W-1:0]      reg_long_press;
	logic [THR_W-1:0]      reg_double_click;
	mode_t                 key_mode [NUM_KEYS];
	logic [TIMER_BITS-1:0] key_timer [NUM_KEYS];
	logic                  key_level [NUM_KEYS];

	predicted_t pending_events[$];
	int         mismatches    = 0;
	int         idle_cycles   = 0;
	int         send_gap_max  = 0;
	int         recv_gap_max  = 0;
	int         receiver_hold = 0;
	logic       run_level [NUM_KEYS];
	int         run_left [NUM_KEYS];

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [TIMER_BITS-1:0] timer_step(logic [TIMER_BITS-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	function automatic predicted_t classify_tick(logic [KEY_W-1:0] k, logic pin);
		predicted_t            ev;
		mode_t                 mode;
		logic [TIMER_BITS-1:0] t;
		logic                  lvl;
		logic                  last;
		ev.key  = k;
		ev.code = EV_NONE;
		ev.held = 1'b0;
		if (int'(k) >= int'(reg_key_count) || int'(k) >= NUM_KEYS)
			return ev;
		lvl  = pin ^ reg_polarity[k];
		last = key_level[k];
		mode = key_mode[k];
		t    = key_timer[k];
		case (mode)
			MODE_IDLE: begin
				if (lvl && !last) begin
					mode = MODE_DEBOUNCE;
					t    = '0;
				end
			end
			MODE_DEBOUNCE: begin
				if (lvl) begin
					t = timer_step(t);
					if (t >= reg_debounce) begin
						mode    = MODE_PRESSED;
						t       = '0;
						ev.code = EV_PRESS;
					end
				end else begin
					mode = MODE_IDLE;
				end
			end
			MODE_PRESSED: begin
				if (lvl) begin
					t = timer_step(t);
					if (t >= reg_long_press) begin
						mode    = MODE_LONG;
						ev.code = EV_LONG;
					end
				end else begin
					mode    = MODE_RELEASED;
					t       = '0;
					ev.code = EV_RELEASE;
				end
			end
			MODE_LONG: begin
				if (!lvl) begin
					mode    = MODE_IDLE;
					ev.code = EV_RELEASE;
				end
			end
			MODE_RELEASED: begin
				t = timer_step(t);
				if (lvl && !last) begin
					mode    = MODE_IDLE;
					ev.code = EV_DOUBLE;
				end else if (t >= reg_double_click) begin
					mode    = MODE_IDLE;
					ev.code = EV_CLICK;
				end
			end
			default: begin
				mode = MODE_IDLE;
			end
		endcase
		key_mode[k]  = mode;
		key_timer[k] = t;
		key_level[k] = lvl;
		ev.held      = lvl;
		return ev;
	endfunction

	task automatic send_tick(input logic [KEY_W-1:0] k, input logic pin);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid     <= 1'b1;
		tick_ch.key_index <= k;
		tick_ch.pin_level <= pin;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		pending_events.push_back(classify_tick(k, pin));
	endtask

	task automatic wait_for_events();
		tick_ch.valid <= 1'b0;
		while (pending_events.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_KEY_COUNT:    reg_key_count    = value[CNT_W-1:0];
			CFG_POLARITY:     reg_polarity     = value[7:0];
			CFG_DEBOUNCE:     reg_debounce     = value[THR_W-1:0];
			CFG_LONG_PRESS:   reg_long_press   = value[THR_W-1:0];
			CFG_DOUBLE_CLICK: reg_double_click = value[THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [CNT_W-1:0] count, input logic [7:0] pol,
		input logic [THR_W-1:0] deb, input logic [THR_W-1:0] lng,
		input logic [THR_W-1:0] dbl);
		wait_for_events();
		cfg_write(CFG_KEY_COUNT, CFG_DATA_W'(count));
		cfg_write(CFG_POLARITY, CFG_DATA_W'(pol));
		cfg_write(CFG_DEBOUNCE, CFG_DATA_W'(deb));
		cfg_write(CFG_LONG_PRESS, CFG_DATA_W'(lng));
		cfg_write(CFG_DOUBLE_CLICK, CFG_DATA_W'(dbl));
		cfg_ch.valid <= 1'b0;
	endtask

	// Each key follows runs of held and let-go ticks, with some raw noise mixed in.
	task automatic send_random_tick(input int run_max, output logic counted);
		logic [KEY_W-1:0] k;
		logic             pin;
		int               active;
		active = (int'(reg_key_count) < NUM_KEYS) ? int'(reg_key_count) : NUM_KEYS;
		if (active == 0 || $urandom_range(0, 9) == 0)
			k = KEY_W'($urandom_range(0, NUM_KEYS - 1));
		else
			k = KEY_W'($urandom_range(0, active - 1));
		if (run_left[k] == 0) begin
			run_level[k] = ~run_level[k];
			run_left[k]  = $urandom_range(1, run_max);
		end
		run_left[k]--;
		pin = run_level[k] ^ reg_polarity[k];
		if ($urandom_range(0, 11) == 0)
			pin = 1'($urandom_range(0, 1));
		counted = int'(k) < active;
		send_tick(k, pin);
	endtask

	task automatic random_phase(input logic [CNT_W-1:0] count, input logic [7:0] pol,
		input logic [THR_W-1:0] deb, input logic [THR_W-1:0] lng,
		input logic [THR_W-1:0] dbl, input int send_max, input int recv_max,
		input int items, input int run_max);
		int   done;
		logic counted;
		apply_settings(count, pol, deb, lng, dbl);
		send_gap_max = send_max;
		recv_gap_max = recv_max;
		done = 0;
		while (done < items) begin
			send_random_tick(run_max, counted);
			if (counted)
				done++;
		end
	endtask

	task automatic test_unregistered_keys();
		send_gap_max = 3;
		recv_gap_max = 3;
		send_tick(3'd0, 1'b0);
		send_tick(3'd7, 1'b1);
		apply_settings(4'd0, 8'h5A, 16'd1, 16'd2, 16'd3);
		send_tick(3'd3, 1'b0);
		send_tick(3'd4, 1'b1);
	endtask

	task automatic test_zero_thresholds();
		logic pins [12] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
			1'b1, 1'b1, 1'b0, 1'b1};
		apply_settings(4'd8, 8'h00, 16'd0, 16'd0, 16'd0);
		send_gap_max = 18;
		recv_gap_max = 18;
		foreach (pins[i])
			send_tick(3'd7, pins[i]);
	endtask

	task automatic test_polarity_and_thresholds();
		logic low_pins [7]  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
		logic high_pins [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
		apply_settings(4'd5, 8'h10, 16'd2, 16'd3, 16'd2);
		foreach (low_pins[i])
			send_tick(3'd4, low_pins[i]);
		send_tick(3'd5, 1'b1);
		foreach (high_pins[i])
			send_tick(3'd0, high_pins[i]);
	endtask

	task automatic test_timer_extremes();
		apply_settings(4'd1, 8'h01, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_gap_max = 0;
		recv_gap_max = 0;
		repeat (150) send_tick(3'd0, 1'b0);
		repeat (50) send_tick(3'd0, 1'b1);
	endtask

	task automatic test_backpressure();
		logic counted;
		apply_settings(4'd8, 8'h0F, 16'd1, 16'd4, 16'd3);
		send_gap_max  = 0;
		recv_gap_max  = 0;
		receiver_hold = 300;
		repeat (60) send_random_tick(10, counted);
		wait_for_events();
	endtask

	task automatic test_random_traffic();
		random_phase(4'd8, 8'($urandom), THR_W'($urandom_range(0, 3)),
			THR_W'($urandom_range(0, 10)), THR_W'($urandom_range(0, 8)),
			18, 18, 200, 18);
		random_phase(CNT_W'($urandom_range(1, 7)), 8'($urandom),
			THR_W'($urandom_range(0, 3)), THR_W'($urandom_range(0, 10)),
			THR_W'($urandom_range(0, 8)), 0, 0, 150, 18);
		random_phase(4'd15, 8'h00, THR_W'($urandom_range(0, 3)),
			THR_W'($urandom_range(0, 10)), THR_W'($urandom_range(0, 8)),
			18, 0, 200, 18);
		random_phase(4'd8, 8'hFF, THR_W'($urandom_range(0, 3)),
			THR_W'($urandom_range(0, 10)), THR_W'($urandom_range(0, 8)),
			0, 18, 200, 18);
		random_phase(4'd8, 8'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF, 18, 18, 100, 18);
		random_phase(4'd8, 8'($urandom), THR_W'($urandom_range(0, 3)),
			THR_W'($urandom_range(0, 10)), THR_W'($urandom_range(0, 8)),
			18, 18, 250, 18);
	endtask

	initial begin : receiver
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (receiver_hold > 0) begin
				result_ch.ready <= 1'b0;
				repeat (receiver_hold) @(posedge clk);
				receiver_hold = 0;
			end
			stall = $urandom_range(0, recv_gap_max);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
		end
	end

	always @(posedge clk) begin : result_check
		predicted_t exp_ev;
		if (arst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result at %0t: key %0d code %0d held %0b",
						$time, result_ch.event_key, result_ch.event_code, result_ch.is_held);
			end else begin
				exp_ev = pending_events.pop_front();
				if (result_ch.event_key !== exp_ev.key || result_ch.event_code !== exp_ev.code
					|| result_ch.is_held !== exp_ev.held) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch at %0t: expected key %0d code %0d held %0b",
							$time, exp_ev.key, exp_ev.code, exp_ev.held);
						$display("  got key %0d code %0d held %0b",
							result_ch.event_key, result_ch.event_code, result_ch.is_held);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1)
			|| (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			|| (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		arst_n            = 1'b0;
		tick_ch.valid     = 1'b0;
		tick_ch.key_index = '0;
		tick_ch.pin_level = 1'b0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_KEY_COUNT;
		cfg_ch.data       = '0;
		reg_key_count     = 4'd0;
		reg_polarity      = 8'hFF;
		reg_debounce      = 16'd20;
		reg_long_press    = 16'd1000;
		reg_double_click  = 16'd300;
		for (int k = 0; k < NUM_KEYS; k++) begin
			key_mode[k]  = MODE_IDLE;
			key_timer[k] = '0;
			key_level[k] = 1'b0;
			run_level[k] = 1'b0;
			run_left[k]  = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unregistered_keys();
		test_zero_thresholds();
		test_polarity_and_thresholds();
		test_timer_extremes();
		test_backpressure();
		test_random_traffic();
		wait_for_events();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
